// ===== sv/gregorian_day_difference_macros.svh =====
// Assertion macros used by the day difference controller.
`ifndef GREGORIAN_DAY_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DAY_DIFFERENCE_MACROS_SVH

`ifndef SYNTH

// Checks a condition at every clock edge outside reset.
`define GDD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Checks that a trigger is followed by a condition in the next cycle.
`define GDD_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("assertion failed");

`else

`define GDD_ASSERT(lbl, cond)
`define GDD_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ===== sv/gdd_pkg.sv =====
// Types, constants and calendar tables for the day difference block.
package gdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;
  localparam int unsigned CentW  = 8;

  // Reciprocal of 100 scaled by 2**19; exact for every 14-bit year.
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = 27;
  localparam logic [ProdW-1:0] Recip100 = ProdW'(5243);

  localparam logic [YearW-1:0]  YearMax = YearW'(9999);
  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StDivStart,
    StChkStart,
    StNumStart,
    StDivEnd,
    StChkEnd,
    StNumEnd,
    StFinish
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic sel_end;
    logic do_div;
    logic do_chk;
    logic do_num;
    logic load_out;
  } cmd_t;

  // Length of a month; 0 for a month code that means nothing.
  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year that lie before the first of a month.
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/gdd_datapath.sv =====
// Datapath: operand registers, year splitter, day number builder and result register.
module gdd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gdd_pkg::cmd_t                   cmd_i,
  input  logic [47:0]                     in_data_i,
  output logic [gdd_pkg::CountW-1:0]      day_count_o,
  output logic                            date_invalid_o
);

  logic [gdd_pkg::DayW-1:0]   sd_q, ed_q;
  logic [gdd_pkg::MonthW-1:0] sm_q, em_q;
  logic [gdd_pkg::YearW-1:0]  sy_q, ey_q;
  logic                       inc_q;

  logic [gdd_pkg::CentW-1:0]  cent_q;
  logic [gdd_pkg::CentW-1:0]  pcent_q, pcent_d;
  logic                       leap_q, leap_d;
  logic                       bad_q, bad_d;
  logic                       ok;
  logic [gdd_pkg::CountW-1:0] a_q, b_q, num;
  logic [gdd_pkg::CountW-1:0] count_q, count_d;
  logic                       inv_q;

  logic [gdd_pkg::DayW-1:0]   d_sel;
  logic [gdd_pkg::MonthW-1:0] m_sel;
  logic [gdd_pkg::YearW-1:0]  y_sel, py, rem;
  logic [gdd_pkg::ProdW-1:0]  prod;
  logic                       rem_zero;
  logic [gdd_pkg::CountW-1:0] diff;

  // Operand selection between the start and the end date.
  assign d_sel = cmd_i.sel_end ? ed_q : sd_q;
  assign m_sel = cmd_i.sel_end ? em_q : sm_q;
  assign y_sel = cmd_i.sel_end ? ey_q : sy_q;

  // Year divided by 100 through the reciprocal multiplier.
  assign prod = gdd_pkg::ProdW'(y_sel) * gdd_pkg::Recip100;

  // Remainder by 100, leap year test and validity of the selected date.
  always_comb begin
    rem      = y_sel - gdd_pkg::YearW'(cent_q) * gdd_pkg::YearW'(100);
    rem_zero = (rem == '0);
    leap_d   = ((y_sel[1:0] == 2'b00) && !rem_zero) || (rem_zero && (cent_q[1:0] == 2'b00));
    pcent_d  = rem_zero ? cent_q - 8'd1 : cent_q;
    ok       = (y_sel != '0) && (y_sel <= gdd_pkg::YearMax) &&
               (m_sel >= gdd_pkg::MonthJan) && (m_sel <= gdd_pkg::MonthDec) &&
               (d_sel != '0) && (d_sel <= gdd_pkg::days_in_month(m_sel, leap_d));
    bad_d    = bad_q | ~ok;
  end

  // Ordinal day number of the selected date; the first day of year one is 1.
  always_comb begin
    py  = y_sel - 14'd1;
    num = gdd_pkg::CountW'(py) * 22'd365
        + gdd_pkg::CountW'(py >> 2)
        - gdd_pkg::CountW'(pcent_q)
        + gdd_pkg::CountW'(pcent_q >> 2)
        + gdd_pkg::CountW'(gdd_pkg::days_before_month(m_sel))
        + gdd_pkg::CountW'((m_sel > gdd_pkg::MonthFeb) && leap_q)
        + gdd_pkg::CountW'(d_sel);
  end

  // Count: zero for a bad date, else span (zero if end <= start) plus end day flag.
  always_comb begin
    diff    = (a_q < b_q) ? b_q - a_q : '0;
    count_d = bad_q ? '0 : diff + gdd_pkg::CountW'(inc_q);
  end

  // Error flag is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      bad_q <= 1'b0;
    end else if (cmd_i.do_chk) begin
      bad_q <= bad_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sd_q  <= in_data_i[4:0];
      sm_q  <= in_data_i[8:5];
      sy_q  <= in_data_i[22:9];
      ed_q  <= in_data_i[27:23];
      em_q  <= in_data_i[31:28];
      ey_q  <= in_data_i[45:32];
      inc_q <= in_data_i[46];
    end
    if (cmd_i.do_div) begin
      cent_q <= prod[gdd_pkg::RecipShift +: gdd_pkg::CentW];
    end
    if (cmd_i.do_chk) begin
      leap_q  <= leap_d;
      pcent_q <= pcent_d;
    end
    if (cmd_i.do_num) begin
      if (cmd_i.sel_end) begin
        b_q <= num;
      end else begin
        a_q <= num;
      end
    end
    if (cmd_i.load_out) begin
      count_q <= count_d;
      inv_q   <= bad_q;
    end
  end

  assign day_count_o    = count_q;
  assign date_invalid_o = inv_q;

endmodule

// ===== sv/gdd_ctrl.sv =====
// Controller: sequencer over the two dates and the handshakes of both sides.
`include "gregorian_day_difference_macros.svh"

module gdd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdd_pkg::cmd_t cmd_o
);

  gdd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdd_pkg::StIdle:     if (in_valid_i) state_d = gdd_pkg::StDivStart;
      gdd_pkg::StDivStart: state_d = gdd_pkg::StChkStart;
      gdd_pkg::StChkStart: state_d = gdd_pkg::StNumStart;
      gdd_pkg::StNumStart: state_d = gdd_pkg::StDivEnd;
      gdd_pkg::StDivEnd:   state_d = gdd_pkg::StChkEnd;
      gdd_pkg::StChkEnd:   state_d = gdd_pkg::StNumEnd;
      gdd_pkg::StNumEnd:   state_d = gdd_pkg::StFinish;
      gdd_pkg::StFinish:   if (out_free) state_d = gdd_pkg::StIdle;
      default:             state_d = gdd_pkg::StIdle;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gdd_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      gdd_pkg::StDivStart: cmd_o.do_div = 1'b1;
      gdd_pkg::StChkStart: cmd_o.do_chk = 1'b1;
      gdd_pkg::StNumStart: cmd_o.do_num = 1'b1;
      gdd_pkg::StDivEnd: begin
        cmd_o.sel_end = 1'b1;
        cmd_o.do_div  = 1'b1;
      end
      gdd_pkg::StChkEnd: begin
        cmd_o.sel_end = 1'b1;
        cmd_o.do_chk  = 1'b1;
      end
      gdd_pkg::StNumEnd: begin
        cmd_o.sel_end = 1'b1;
        cmd_o.do_num  = 1'b1;
      end
      gdd_pkg::StFinish: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Output word valid: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdd_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `GDD_ASSERT_NEXT(a_load_shows, cmd_o.load_out, out_valid_o)
  `GDD_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == gdd_pkg::StDivStart)
  `GDD_ASSERT_NEXT(a_end_finishes, state_q == gdd_pkg::StNumEnd, state_q == gdd_pkg::StFinish)
  `GDD_ASSERT(a_no_overwrite, !(cmd_o.load_out && out_valid_q && !out_ready_i))

endmodule

// ===== sv/gregorian_day_difference.sv =====
// Top level of the Gregorian day difference block.
// Each input word carries two dates and an end day flag and yields one output word with
// the day count between them, or zero with the invalid flag set if either date is not a
// real calendar date. One word is worked on at a time: a sequencer passes each date in
// turn through one shared year splitter (a reciprocal multiply by 1/100, then the leap
// test and validity check) and one day number builder, through the divide, check and
// number steps for the start date, then for the end date, then a finish step that loads
// the result; the next input word is taken in the cycle after the result is loaded.
// The result register lets a new word start while the previous result still waits; a
// stalled output only holds the sequencer in its last step.
module gregorian_day_difference (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: start_day[5], start_month[4], start_year[14], end_day[5], end_month[4],
  // end_year[14], include_end[1], one zero pad bit.
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: day_count[22], two zero pad bits.
  output logic [23:0] m_axis_tdata_o,
  // Bit 0: date_invalid.
  output logic        m_axis_tuser_o
);

  gdd_pkg::cmd_t              cmd;
  logic [gdd_pkg::CountW-1:0] day_count;

  // Sequencer.
  gdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic.
  gdd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_data_i      (s_axis_tdata_i),
    .day_count_o    (day_count),
    .date_invalid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, day_count};

endmodule
